### sv/assert_macros.svh
// Assertion helpers for the servo top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hcps_pkg.sv
package hcps_pkg;

  // Field widths
  localparam int POS_W   = 16;
  localparam int LVL_W   = 5;
  localparam int TGT_W   = 13;
  localparam int HALL_W  = 3;
  localparam int STEP_W  = 3;
  localparam int HW_W    = 8;
  localparam int FAR_W   = 12;
  localparam int TMR_W   = 16;
  localparam int RW_W    = 8;
  localparam int DIST_W  = POS_W + 2;
  localparam int CFG_DW  = 16;
  localparam int CFG_AW  = 3;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;

  // Register reset values
  localparam logic [HW_W-1:0]  HOLD_WINDOW_RST   = HW_W'(13);
  localparam logic [FAR_W-1:0] FAR_DISTANCE_RST  = FAR_W'(120);
  localparam logic [TMR_W-1:0] STALL_LIMIT_RST   = TMR_W'(60000);
  localparam logic [TMR_W-1:0] HOLD_PRESET_RST   = TMR_W'(45000);
  localparam logic [RW_W-1:0]  REPORT_WINDOW_RST = RW_W'(15);

  // Hall code to commutation step; codes 0 and 7 give step 0 (no drive)
  localparam logic [STEP_W-1:0] STEP_OF_HALL [8] = '{
    3'd0, 3'd1, 3'd3, 3'd2, 3'd5, 3'd6, 3'd4, 3'd0
  };

  // Step to active phases: bit0 phase_a, bit1 phase_b, bit2 phase_c
  localparam logic [2:0] PHASES_OF_STEP [8] = '{
    3'd0, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd0
  };

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_MOVE   = 2'd2,
    MODE_HALT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DRIVE    = 3'd0,
    KIND_REACHED  = 3'd1,
    KIND_MISSED   = 3'd2,
    KIND_ACCEPTED = 3'd3,
    KIND_THERE    = 3'd4,
    KIND_STOPPED  = 3'd5
  } kind_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_HOLD_WINDOW   = 3'd0,
    CFG_FAR_DISTANCE  = 3'd1,
    CFG_STALL_LIMIT   = 3'd2,
    CFG_HOLD_PRESET   = 3'd3,
    CFG_REPORT_WINDOW = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [HW_W-1:0]  hold_window;
    logic [FAR_W-1:0] far_distance;
    logic [TMR_W-1:0] stall_limit;
    logic [TMR_W-1:0] hold_preset;
    logic [RW_W-1:0]  report_window;
  } cfg_t;

  typedef struct packed {
    mode_t                   mode;
    logic [HALL_W-1:0]       hall_bits;
    logic signed [POS_W-1:0] encoder_position;
    logic [TGT_W-1:0]        target_position;
    logic [LVL_W-1:0]        drive_level;
  } item_t;

  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic [LVL_W-1:0]        phase_a;
    logic [LVL_W-1:0]        phase_b;
    logic [LVL_W-1:0]        phase_c;
    logic signed [POS_W-1:0] position;
    logic [LVL_W-1:0]        level;
  } res_t;

  typedef struct packed {
    logic running;
    logic stall_reported;
  } status_t;

endpackage

### sv/hall_commutated_position_servo.sv
// Channel  | Direction | Carries
// in_      | slave     | command, tick or hall sample word with encoder position
// out_     | master    | drive update or status report word
// cfg_     | write     | window, distance and timer registers
//
// A word is registered on entry, processed combinationally and registered on exit:
// the result word passes both registers, one word per cycle sustained unless the output stalls.
// Samples while stopped or without a hall change, and ticks that trip no pending
// stall report, give no word.
// rst_n is synchronous: motor stopped, no stall report pending, registers at defaults.
// A stalled output holds its word; the input register still takes one more word.
`include "assert_macros.svh"

module hall_commutated_position_servo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] hall_bits, [18:3] encoder_position, [31:19] target_position,
  // [36:32] drive_level, [39:37] zero
  input  logic [hcps_pkg::IN_DW-1:0]      in_tdata,
  // [1:0] mode
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] phase_a, [9:5] phase_b, [14:10] phase_c, [30:15] position,
  // [35:31] level, [39:36] zero
  output logic [hcps_pkg::OUT_DW-1:0]     out_tdata,
  // [2:0] kind
  output logic [2:0]                      out_tuser,
  input  logic                            cfg_we,
  input  logic [hcps_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [hcps_pkg::CFG_DW-1:0]     cfg_wdata
);

  hcps_pkg::cfg_t    cfg;
  hcps_pkg::item_t   item_r, item_nxt;
  hcps_pkg::res_t    res_c, res_r;
  hcps_pkg::status_t status;
  logic              in_valid_r, in_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              fire;
  logic              stop_fire;
  logic              drive_ok;

  hcps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hcps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .res    (res_c),
    .status (status)
  );

  // Process the held word when the result register is free or draining
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  // Unpack the input word
  always_comb begin
    item_nxt.mode             = hcps_pkg::mode_t'(in_tuser);
    item_nxt.hall_bits        = in_tdata[2:0];
    item_nxt.encoder_position = signed'(in_tdata[18:3]);
    item_nxt.target_position  = in_tdata[31:19];
    item_nxt.drive_level      = in_tdata[36:32];
  end

  // Advance the valid flags
  always_comb begin
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (fire)              in_valid_nxt = 1'b0;
    else                        in_valid_nxt = in_valid_r;

    if (fire)            out_valid_nxt = res_c.valid;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) item_r <= item_nxt;
    if (fire && res_c.valid)    res_r  <= res_c;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {4'b0000, res_r.level, res_r.position,
                       res_r.phase_c, res_r.phase_b, res_r.phase_a};

  // Conditions watched by the checks below
  assign stop_fire = fire && res_c.valid && (res_c.kind == hcps_pkg::KIND_STOPPED);
  assign drive_ok  = (res_r.kind == hcps_pkg::KIND_DRIVE) ||
                     (res_r.phase_a == '0 && res_r.phase_b == '0 && res_r.phase_c == '0);

  `ASSERT_NEXT(a_stop_halts, stop_fire, !status.running, "stop word left motor running")
  `ASSERT_ALWAYS(a_armed_running, status.stall_reported || status.running, "armed while stopped")
  `ASSERT_NEXT(a_accept_held, in_tvalid && in_tready, in_valid_r, "accepted word not held")
  `ASSERT_ALWAYS(a_report_no_drive, !out_valid_r || drive_ok, "report word carries phase drive")

endmodule

### sv/hcps_cfg.sv
module hcps_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcps_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [hcps_pkg::CFG_DW-1:0]    cfg_wdata,
  output hcps_pkg::cfg_t                 cfg
);

  hcps_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hcps_pkg::cfg_idx_t'(cfg_addr))
        hcps_pkg::CFG_HOLD_WINDOW:
          cfg_nxt.hold_window = cfg_wdata[hcps_pkg::HW_W-1:0];
        hcps_pkg::CFG_FAR_DISTANCE:
          cfg_nxt.far_distance = cfg_wdata[hcps_pkg::FAR_W-1:0];
        hcps_pkg::CFG_STALL_LIMIT:
          cfg_nxt.stall_limit = cfg_wdata[hcps_pkg::TMR_W-1:0];
        hcps_pkg::CFG_HOLD_PRESET:
          cfg_nxt.hold_preset = cfg_wdata[hcps_pkg::TMR_W-1:0];
        hcps_pkg::CFG_REPORT_WINDOW:
          cfg_nxt.report_window = cfg_wdata[hcps_pkg::RW_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_window   <= hcps_pkg::HOLD_WINDOW_RST;
      cfg_r.far_distance  <= hcps_pkg::FAR_DISTANCE_RST;
      cfg_r.stall_limit   <= hcps_pkg::STALL_LIMIT_RST;
      cfg_r.hold_preset   <= hcps_pkg::HOLD_PRESET_RST;
      cfg_r.report_window <= hcps_pkg::REPORT_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/hcps_ctrl.sv
module hcps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  hcps_pkg::item_t     item,
  input  hcps_pkg::cfg_t      cfg,
  output hcps_pkg::res_t      res,
  output hcps_pkg::status_t   status
);

  localparam int DW = hcps_pkg::DIST_W;

  logic                              running_r, running_nxt;
  logic                              reported_r, reported_nxt;
  logic [hcps_pkg::HALL_W-1:0]       last_hall_r, last_hall_nxt;
  logic [hcps_pkg::TGT_W-1:0]        target_r, target_nxt;
  logic [hcps_pkg::LVL_W-1:0]        level_r, level_nxt;
  logic [hcps_pkg::TMR_W-1:0]        timer_r, timer_nxt;

  logic signed [DW-1:0]              pos_x, tgt_x, delta, neg_dist;
  logic signed [DW-1:0]              hold_x, far_x, rep_x;
  logic                              in_hold, in_report;
  logic [hcps_pkg::STEP_W-1:0]       s, step;
  logic [2:0]                        ph;
  logic [hcps_pkg::LVL_W-1:0]        lv;
  logic [hcps_pkg::TMR_W-1:0]        timer_inc;

  // Distance to target and window compares
  always_comb begin
    pos_x     = {{2{item.encoder_position[hcps_pkg::POS_W-1]}}, item.encoder_position};
    tgt_x     = signed'(DW'(target_r));
    delta     = pos_x - tgt_x;
    neg_dist  = tgt_x - pos_x;
    hold_x    = signed'(DW'(cfg.hold_window));
    far_x     = signed'(DW'(cfg.far_distance));
    rep_x     = signed'(DW'(cfg.report_window));
    in_hold   = (delta < hold_x) && (neg_dist < hold_x);
    in_report = (delta < rep_x) && (neg_dist < rep_x);
  end

  // Pick the commutation step and drive level for a hall change
  always_comb begin
    s  = hcps_pkg::STEP_OF_HALL[item.hall_bits];
    lv = level_r >> 1;
    if (in_hold) begin
      step = s;
    end else if (delta < 0) begin
      if (neg_dist > far_x) begin
        step = (s > 3'd2) ? s - 3'd2 : s + 3'd4;
        lv   = level_r;
      end else begin
        step = (s > 3'd1) ? s - 3'd1 : 3'd6;
      end
    end else begin
      if (delta > far_x) begin
        step = (s < 3'd5) ? s + 3'd2 : s - 3'd4;
        lv   = level_r;
      end else begin
        step = (s < 3'd6) ? s + 3'd1 : 3'd1;
      end
    end
    if (s == 3'd0) step = 3'd0;
    ph = hcps_pkg::PHASES_OF_STEP[step];
  end

  // Next state and result for the word at hand
  always_comb begin
    running_nxt   = running_r;
    reported_nxt  = reported_r;
    last_hall_nxt = last_hall_r;
    target_nxt    = target_r;
    level_nxt     = level_r;
    timer_nxt     = timer_r;
    timer_inc     = (timer_r == '1) ? timer_r : timer_r + 1'b1;

    res          = '0;
    res.kind     = hcps_pkg::KIND_DRIVE;

    case (item.mode)
      hcps_pkg::MODE_SAMPLE: begin
        if (running_r && (item.hall_bits != last_hall_r)) begin
          last_hall_nxt = item.hall_bits;
          timer_nxt     = in_hold ? cfg.hold_preset : '0;
          res.valid     = 1'b1;
          res.phase_a   = ph[0] ? lv : '0;
          res.phase_b   = ph[1] ? lv : '0;
          res.phase_c   = ph[2] ? lv : '0;
        end
      end
      hcps_pkg::MODE_TICK: begin
        timer_nxt = timer_inc;
        if ((timer_inc > cfg.stall_limit) && !reported_r) begin
          running_nxt  = 1'b0;
          reported_nxt = 1'b1;
          res.valid    = 1'b1;
          res.kind     = in_report ? hcps_pkg::KIND_REACHED : hcps_pkg::KIND_MISSED;
          res.position = item.encoder_position;
        end
      end
      hcps_pkg::MODE_MOVE: begin
        level_nxt    = item.drive_level;
        res.valid    = 1'b1;
        res.position = signed'(hcps_pkg::POS_W'(item.target_position));
        if (hcps_pkg::POS_W'(item.target_position) != item.encoder_position) begin
          target_nxt   = item.target_position;
          running_nxt  = 1'b1;
          timer_nxt    = '0;
          reported_nxt = 1'b0;
          res.kind     = hcps_pkg::KIND_ACCEPTED;
        end else begin
          res.kind     = hcps_pkg::KIND_THERE;
        end
      end
      default: begin
        level_nxt    = item.drive_level;
        target_nxt   = item.target_position;
        running_nxt  = 1'b0;
        reported_nxt = 1'b1;
        res.valid    = 1'b1;
        res.kind     = hcps_pkg::KIND_STOPPED;
        res.position = signed'(hcps_pkg::POS_W'(item.target_position));
      end
    endcase
    res.level = level_nxt;
  end

  // Commit state when the word is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      reported_r  <= 1'b1;
      last_hall_r <= '0;
      target_r    <= '0;
      level_r     <= '0;
      timer_r     <= '0;
    end else if (fire) begin
      running_r   <= running_nxt;
      reported_r  <= reported_nxt;
      last_hall_r <= last_hall_nxt;
      target_r    <= target_nxt;
      level_r     <= level_nxt;
      timer_r     <= timer_nxt;
    end
  end

  assign status.running        = running_r;
  assign status.stall_reported = reported_r;

endmodule

### verif/hcps_scoreboard.sv
`timescale 1ns / 100ps

module hcps_scoreboard
  import hcps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  // [2:0] hall_bits, [18:3] encoder_position, [31:19] target_position,
  // [36:32] drive_level, [39:37] zero
  input  logic [IN_DW-1:0]    in_tdata,
  // [1:0] mode
  input  logic [1:0]          in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  // [4:0] phase_a, [9:5] phase_b, [14:10] phase_c, [30:15] position,
  // [35:31] level, [39:36] zero
  input  logic [OUT_DW-1:0]   out_tdata,
  // [2:0] kind
  input  logic [2:0]          out_tuser,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output int                  pending,
  output int                  failures
);

  // Hall code to step, and step to energized phases (bit0 a, bit1 b, bit2 c)
  localparam logic [2:0] HALL_STEP [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd5, 3'd6, 3'd4, 3'd0};
  localparam logic [2:0] STEP_COILS [8] = '{3'd0, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd0};

  // Register copies
  int               hold_window;
  int               far_distance;
  int               report_window;
  logic [TMR_W-1:0] stall_limit;
  logic [TMR_W-1:0] hold_preset;

  // Motor state
  logic             spinning;
  logic             stall_done;
  logic [2:0]       last_hall;
  int               aim;
  logic [LVL_W-1:0] level_store;
  logic [TMR_W-1:0] stall_timer;

  res_t servo_replies[$];
  int   fail_count = 0;

  assign failures = fail_count;

  task automatic log_failure(string msg);
    fail_count++;
    $display("%0t ns: servo mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want)
      log_failure($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Compute the reply to one accepted word and advance the motor state
  function automatic res_t servo_respond(item_t word);
    res_t             r;
    int               pos;
    int               gap;
    int               s;
    int               st;
    logic [2:0]       coils;
    logic [LVL_W-1:0] lv;
    r = '0;
    pos = int'(word.encoder_position);
    gap = pos - aim;
    case (word.mode)
      MODE_SAMPLE: begin
        if (spinning && word.hall_bits != last_hall) begin
          last_hall = word.hall_bits;
          stall_timer = '0;
          s = int'(HALL_STEP[word.hall_bits]);
          lv = level_store >> 1;
          if (gap < hold_window && -gap < hold_window) begin
            st = s;
            stall_timer = hold_preset;
          end else if (gap < 0) begin
            if (-gap > far_distance) begin
              st = (s > 2) ? s - 2 : s + 4;
              lv = level_store;
            end else begin
              st = (s > 1) ? s - 1 : 6;
            end
          end else begin
            if (gap > far_distance) begin
              st = (s < 5) ? s + 2 : s - 4;
              lv = level_store;
            end else begin
              st = (s < 6) ? s + 1 : 1;
            end
          end
          // invalid hall codes drive nothing
          if (s < 1 || s > 6) st = 0;
          coils = STEP_COILS[st[2:0]];
          r.valid = 1'b1;
          r.kind = KIND_DRIVE;
          r.phase_a = coils[0] ? lv : '0;
          r.phase_b = coils[1] ? lv : '0;
          r.phase_c = coils[2] ? lv : '0;
        end
      end
      MODE_TICK: begin
        if (stall_timer != '1) stall_timer = stall_timer + 1'b1;
        if (stall_timer > stall_limit && !stall_done) begin
          spinning = 1'b0;
          stall_done = 1'b1;
          r.valid = 1'b1;
          r.kind = (gap < report_window && -gap < report_window) ? KIND_REACHED : KIND_MISSED;
          r.position = word.encoder_position;
        end
      end
      MODE_MOVE: begin
        level_store = word.drive_level;
        r.valid = 1'b1;
        r.position = POS_W'(word.target_position);
        if (int'(word.target_position) != pos) begin
          aim = int'(word.target_position);
          spinning = 1'b1;
          stall_timer = '0;
          stall_done = 1'b0;
          r.kind = KIND_ACCEPTED;
        end else begin
          r.kind = KIND_THERE;
        end
      end
      default: begin
        level_store = word.drive_level;
        aim = int'(word.target_position);
        spinning = 1'b0;
        stall_done = 1'b1;
        r.valid = 1'b1;
        r.kind = KIND_STOPPED;
        r.position = POS_W'(word.target_position);
      end
    endcase
    r.level = level_store;
    return r;
  endfunction

  always @(posedge clk) begin
    item_t word;
    res_t  want;
    res_t  reply;
    if (!rst_n) begin
      hold_window = int'(HOLD_WINDOW_RST);
      far_distance = int'(FAR_DISTANCE_RST);
      report_window = int'(REPORT_WINDOW_RST);
      stall_limit = STALL_LIMIT_RST;
      hold_preset = HOLD_PRESET_RST;
      spinning = 1'b0;
      stall_done = 1'b1;
      last_hall = '0;
      aim = 0;
      level_store = '0;
      stall_timer = '0;
      servo_replies.delete();
    end else begin
      // Compare the outgoing word with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (servo_replies.size() == 0) begin
          log_failure($sformatf("unexpected word of kind %0d", out_tuser));
        end else begin
          want = servo_replies.pop_front();
          check_field("kind", out_tuser, want.kind);
          check_field("phase_a", out_tdata[4:0], want.phase_a);
          check_field("phase_b", out_tdata[9:5], want.phase_b);
          check_field("phase_c", out_tdata[14:10], want.phase_c);
          check_field("position", $signed(out_tdata[30:15]), want.position);
          check_field("level", out_tdata[35:31], want.level);
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_HOLD_WINDOW:   hold_window = int'(cfg_wdata[HW_W-1:0]);
          CFG_FAR_DISTANCE:  far_distance = int'(cfg_wdata[FAR_W-1:0]);
          CFG_STALL_LIMIT:   stall_limit = cfg_wdata[TMR_W-1:0];
          CFG_HOLD_PRESET:   hold_preset = cfg_wdata[TMR_W-1:0];
          CFG_REPORT_WINDOW: report_window = int'(cfg_wdata[RW_W-1:0]);
          default: ;
        endcase
      end
      // Predict the reply to an accepted input word
      if (in_tvalid && in_tready) begin
        word.mode = mode_t'(in_tuser);
        word.hall_bits = in_tdata[2:0];
        word.encoder_position = in_tdata[18:3];
        word.target_position = in_tdata[31:19];
        word.drive_level = in_tdata[36:32];
        reply = servo_respond(word);
        if (reply.valid) servo_replies.push_back(reply);
      end
    end
    pending <= servo_replies.size();
  end

endmodule

### verif/hall_commutated_position_servo_tb.sv
`timescale 1ns / 100ps

module hall_commutated_position_servo_tb;
  import hcps_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HALL_RING [6] = '{1, 3, 2, 6, 4, 5};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // [2:0] hall_bits, [18:3] encoder_position, [31:19] target_position,
  // [36:32] drive_level, [39:37] zero
  logic [IN_DW-1:0]   in_tdata = '0;
  // [1:0] mode
  logic [1:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // [4:0] phase_a, [9:5] phase_b, [14:10] phase_c, [30:15] position,
  // [35:31] level, [39:36] zero
  logic [OUT_DW-1:0]  out_tdata;
  // [2:0] kind
  logic [2:0]         out_tuser;
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;

  int pending;
  int failures;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Stimulus view of the current settings and motor target
  int cur_hw = 13;
  int cur_fd = 120;
  int aim = 0;
  int hall_now = 1;
  int ring_pos = 0;

  hall_commutated_position_servo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  hcps_scoreboard servo_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .failures   (failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one word, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_word(mode_t mode, int hall, int enc, int tgt, int lvl);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {3'b000, LVL_W'(lvl), TGT_W'(tgt), POS_W'(enc), HALL_W'(hall)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold input idle until every predicted word has come out, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_servo(int hw, int fd, int sl, int hp, int rw);
    cfg_idx_t idx [5];
    int       val [5];
    idx = '{CFG_HOLD_WINDOW, CFG_FAR_DISTANCE, CFG_STALL_LIMIT, CFG_HOLD_PRESET,
            CFG_REPORT_WINDOW};
    val = '{hw, fd, sl, hp, rw};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= CFG_DW'(val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_hw = hw;
    cur_fd = fd;
  endtask

  function automatic int pick_target();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 8188);
    return $urandom_range(0, 2047) * 4;
  endfunction

  // Distance from the target: inside hold, near, far or anywhere
  function automatic int pick_offset();
    int mag;
    case ($urandom_range(0, 3))
      0: mag = $urandom_range(0, cur_hw);
      1: mag = $urandom_range(0, cur_fd + 1);
      2: mag = $urandom_range(cur_fd, cur_fd + 3000);
      default: mag = $urandom_range(0, 40000);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Advance the hall code mostly along the six-step ring
  task automatic turn_hall();
    case ($urandom_range(0, 9))
      0: ;
      1: hall_now = $urandom_range(0, 7);
      2, 3: begin
        ring_pos = (ring_pos + 5) % 6;
        hall_now = HALL_RING[ring_pos];
      end
      default: begin
        ring_pos = (ring_pos + 1) % 6;
        hall_now = HALL_RING[ring_pos];
      end
    endcase
  endtask

  // A move followed by a random mix of hall samples, ticks, commands and noise
  task automatic drive_motion(int count);
    int pick;
    int tgt;
    int enc;
    aim = pick_target();
    send_word(MODE_MOVE, hall_now, aim + 2 * cur_fd + 1, aim, $urandom_range(0, 31));
    for (int k = 1; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        tgt = pick_target();
        enc = ($urandom_range(0, 9) == 0) ? tgt : tgt + pick_offset();
        if (enc != tgt) aim = tgt;
        send_word(MODE_MOVE, $urandom_range(0, 7), enc, tgt, $urandom_range(0, 31));
      end else if (pick < 14) begin
        aim = pick_target();
        send_word(MODE_HALT, $urandom_range(0, 7), $urandom_range(0, 65535), aim,
                  $urandom_range(0, 31));
      end else if (pick < 22) begin
        send_word(mode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                  $urandom_range(0, 65535), $urandom_range(0, 8188), $urandom_range(0, 31));
      end else if (pick < 52) begin
        send_word(MODE_TICK, $urandom_range(0, 7), aim + pick_offset(),
                  $urandom_range(0, 8188), $urandom_range(0, 31));
      end else begin
        turn_hall();
        send_word(MODE_SAMPLE, hall_now, aim + pick_offset(), $urandom_range(0, 8188),
                  $urandom_range(0, 31));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default registers, every hall code, both far and near sides
    send_word(MODE_SAMPLE, 1, 0, 0, 0);
    send_word(MODE_TICK, 0, 0, 0, 0);
    send_word(MODE_MOVE, 0, 100, 100, 31);
    send_word(MODE_MOVE, 0, -32768, 8188, 31);
    send_word(MODE_SAMPLE, 1, -32768, 0, 0);
    send_word(MODE_SAMPLE, 1, -32768, 0, 0);
    send_word(MODE_SAMPLE, 3, 8188 - 50, 0, 0);
    send_word(MODE_SAMPLE, 2, 8188 + 50, 0, 0);
    send_word(MODE_SAMPLE, 6, 8188 + 500, 0, 0);
    send_word(MODE_SAMPLE, 4, 8188 + 500, 0, 0);
    send_word(MODE_SAMPLE, 5, 8188, 0, 0);
    send_word(MODE_SAMPLE, 7, 8188, 0, 0);
    send_word(MODE_SAMPLE, 0, 32767, 0, 0);
    send_word(MODE_TICK, 7, 8188, 8191, 31);
    settle();

    // Directed: short stall timer, reached and missed reports, stop, already there
    program_servo(13, 120, 3, 5, 15);
    send_word(MODE_MOVE, 0, 1000, 0, 0);
    send_word(MODE_SAMPLE, 1, 5, 0, 0);
    send_word(MODE_TICK, 0, 5, 0, 0);
    send_word(MODE_TICK, 0, 5, 0, 0);
    send_word(MODE_MOVE, 0, 0, 4000, 17);
    send_word(MODE_SAMPLE, 3, 3990, 0, 0);
    send_word(MODE_TICK, 0, 3900, 0, 0);
    send_word(MODE_HALT, 0, 0, 3, 9);
    send_word(MODE_SAMPLE, 2, 0, 0, 0);
    send_word(MODE_MOVE, 0, 5, 5, 1);
    settle();

    // Lowest settings; a zero hold window means no position holds
    program_servo(0, 1, 1, 0, 1);
    drive_motion(90);
    settle();

    // Highest settings, sender idling
    program_servo(255, 4095, 65535, 65535, 255);
    send_gap_pct = 64;
    drive_motion(90);
    settle();

    // Moderate settings, receiver stalling
    program_servo(13, 120, 20, 10, 15);
    send_gap_pct = 0;
    stall_pct = 64;
    drive_motion(100);
    settle();

    // Random settings, both sides idling
    program_servo($urandom_range(1, 255), $urandom_range(1, 4095), $urandom_range(1, 60),
                  $urandom_range(0, 80), $urandom_range(1, 255));
    send_gap_pct = 34;
    stall_pct = 34;
    drive_motion(100);
    settle();

    // Random settings at full rate, with one pause until the output drains
    program_servo($urandom_range(1, 255), $urandom_range(1, 4095), $urandom_range(1, 60),
                  $urandom_range(0, 80), $urandom_range(1, 255));
    send_gap_pct = 0;
    stall_pct = 0;
    drive_motion(60);
    settle();
    drive_motion(60);
    settle();

    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
